[src/assert_macros.svh]
// Assertion macros shared by the scanner modules.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is high.
`define ASP_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/aspscan_pkg.sv]
// Types and constants of the sleep package scanner.
// Depends on nothing; used by every scanner module.
`timescale 1ns / 1ps

package aspscan_pkg;

  localparam logic [7:0] OP_NAME    = 8'h08;
  localparam logic [7:0] OP_PACKAGE = 8'h12;
  localparam logic [7:0] LEN_MULTI  = 8'hC0;
  localparam logic [7:0] PFX_BYTE   = 8'h0A;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_S       = 8'h53;
  localparam logic [7:0] CH_FIVE    = 8'h35;
  localparam logic [7:0] CH_ROOT    = 8'h5C;
  localparam logic [7:0] COUNT_MIN  = 8'd2;

  localparam int RECENT_DEPTH = 6;

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_FEW   = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;

  typedef struct packed {
    logic [1:0] scan_status;
    logic [7:0] sleep_type_a;
    logic [7:0] sleep_type_b;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } result_beat_t;

endpackage

[src/aspscan_if.sv]
// Valid/ready channel interfaces for table bytes and scan reports.
// Depends on nothing.
`timescale 1ns / 1ps

interface aspscan_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] table_byte;
  logic       last_byte;

  modport source (output valid, output table_byte, output last_byte, input ready);
  modport sink   (input valid, input table_byte, input last_byte, output ready);
endinterface

interface aspscan_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] scan_status;
  logic [7:0] sleep_type_a;
  logic [7:0] sleep_type_b;

  modport source (output valid, output scan_status, output sleep_type_a,
                  output sleep_type_b, input ready);
  modport sink   (input valid, input scan_status, input sleep_type_a,
                  input sleep_type_b, output ready);
endinterface

[src/aspscan_parser.sv]
// Per-byte parser: name match window, package phase and held sleep types.
// Depends on aspscan_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aspscan_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [7:0]                table_byte,
  input  logic                      last_byte,
  output aspscan_pkg::result_beat_t res
);
  import aspscan_pkg::*;

  localparam logic [3:0] PH_SCAN  = 4'd0;
  localparam logic [3:0] PH_LEN   = 4'd1;
  localparam logic [3:0] PH_SKIP  = 4'd2;
  localparam logic [3:0] PH_COUNT = 4'd3;
  localparam logic [3:0] PH_A     = 4'd4;
  localparam logic [3:0] PH_A_VAL = 4'd5;
  localparam logic [3:0] PH_B     = 4'd6;
  localparam logic [3:0] PH_B_VAL = 4'd7;
  localparam logic [3:0] PH_DONE  = 4'd8;

  logic [7:0] recent [RECENT_DEPTH];
  logic [3:0] phase;
  logic [7:0] cand_a;
  logic [7:0] held_a;
  logic [7:0] held_b;
  logic [1:0] outcome;

  logic [3:0] phase_next;
  logic [7:0] cand_a_next;
  logic [7:0] held_a_next;
  logic [7:0] held_b_next;
  logic [1:0] outcome_next;
  logic       named;
  logic       prefixed;
  logic       hit;

  assign named    = (recent[3] == CH_UNDER) && (recent[2] == CH_S) &&
                    (recent[1] == CH_FIVE) && (recent[0] == CH_UNDER);
  assign prefixed = (recent[4] == OP_NAME) ||
                    ((recent[5] == OP_NAME) && (recent[4] == CH_ROOT));
  assign hit      = (table_byte == OP_PACKAGE) && named && prefixed;

  always_comb begin
    phase_next   = phase;
    cand_a_next  = cand_a;
    held_a_next  = held_a;
    held_b_next  = held_b;
    outcome_next = outcome;
    case (phase)
      PH_SCAN: begin
        if (hit) begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        phase_next = ((table_byte & LEN_MULTI) != 8'd0) ? PH_SKIP : PH_COUNT;
      end
      PH_SKIP: begin
        phase_next = PH_COUNT;
      end
      PH_COUNT: begin
        if (table_byte < COUNT_MIN) begin
          outcome_next = last_byte ? ST_NONE : ST_FEW;
          phase_next   = PH_DONE;
        end else begin
          phase_next = PH_A;
        end
      end
      PH_A: begin
        if (table_byte == PFX_BYTE) begin
          phase_next = PH_A_VAL;
        end else begin
          cand_a_next = table_byte;
          phase_next  = PH_B;
        end
      end
      PH_A_VAL: begin
        cand_a_next = table_byte;
        phase_next  = PH_B;
      end
      PH_B: begin
        if (table_byte == PFX_BYTE) begin
          phase_next = PH_B_VAL;
        end else begin
          held_a_next  = cand_a;
          held_b_next  = table_byte;
          outcome_next = ST_FOUND;
          phase_next   = PH_DONE;
        end
      end
      PH_B_VAL: begin
        held_a_next  = cand_a;
        held_b_next  = table_byte;
        outcome_next = ST_FOUND;
        phase_next   = PH_DONE;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
  end

  always_comb begin
    res.valid             = step && last_byte;
    res.data.scan_status  = (phase_next == PH_DONE) ? outcome_next : ST_NONE;
    res.data.sleep_type_a = held_a_next;
    res.data.sleep_type_b = held_b_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RECENT_DEPTH; k++) begin
        recent[k] <= 8'd0;
      end
      phase   <= PH_SCAN;
      cand_a  <= 8'd0;
      held_a  <= 8'd0;
      held_b  <= 8'd0;
      outcome <= ST_NONE;
    end else if (step) begin
      held_a <= held_a_next;
      held_b <= held_b_next;
      if (last_byte) begin
        for (int k = 0; k < RECENT_DEPTH; k++) begin
          recent[k] <= 8'd0;
        end
        phase   <= PH_SCAN;
        cand_a  <= 8'd0;
        outcome <= ST_NONE;
      end else begin
        for (int k = RECENT_DEPTH - 1; k > 0; k--) begin
          recent[k] <= recent[k - 1];
        end
        recent[0] <= table_byte;
        phase     <= phase_next;
        cand_a    <= cand_a_next;
        outcome   <= outcome_next;
      end
    end
  end

  `ASP_ASSERT(a_table_restart, clk, rst, (step && last_byte) |=> (phase == PH_SCAN),
    "parser did not restart after the last byte")
  `ASP_ASSERT(a_held_commit_only, clk, rst,
    (held_b != $past(held_b)) |-> $past(step && ((phase == PH_B) || (phase == PH_B_VAL))),
    "held sleep type changed outside a commit")
  `ASP_ASSERT(a_done_is_final, clk, rst,
    (phase == PH_DONE && !(step && last_byte)) |=> (phase == PH_DONE),
    "parser left the done phase before the table ended")

endmodule

[src/aspscan_out_reg.sv]
// Result register holding one scan report until the receiver takes it.
// Depends on aspscan_pkg and the aspscan_out_if interface.
`timescale 1ns / 1ps

module aspscan_out_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  aspscan_pkg::result_beat_t res,
  output logic                      full,
  aspscan_out_if.source             report
);
  import aspscan_pkg::*;

  logic    valid;
  result_t data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res.valid) begin
      valid <= 1'b1;
    end else if (report.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      data <= res.data;
    end
  end

  assign full                = valid;
  assign report.valid        = valid;
  assign report.scan_status  = data.scan_status;
  assign report.sleep_type_a = data.sleep_type_a;
  assign report.sleep_type_b = data.sleep_type_b;

endmodule

[src/aml_sleep_package_scanner_unit.sv]
// Sleep package scanner: takes AML table body bytes, reports the sleep types.
// Usage:
//   bytes  (sink)  : one table byte per beat, last_byte marks the table end.
//   report (source): one beat per table, sent after its last byte, carrying
//                    scan_status and the held sleep_type_a / sleep_type_b.
// Timing:
//   A byte is taken into an input register and parsed from there, and the
//   last byte's report lands in the result register, which drives
//   report.valid. One byte is taken per cycle while no final byte stalls;
//   the input register and the result register set this rate.
// Stall:
//   Non-final bytes flow on while a report waits. A final byte waits in the
//   input register while the previous report is still held, and bytes.ready
//   drops for that time.
// Reset:
//   rst (synchronous) empties both registers, clears the match window and
//   parse phase, and zeroes the held sleep types.
// Depends on aspscan_pkg, aspscan_if, aspscan_parser, aspscan_out_reg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aml_sleep_package_scanner_unit (
  input  logic         clk,
  input  logic         rst,
  aspscan_in_if.sink   bytes,
  aspscan_out_if.source report
);
  import aspscan_pkg::*;

  logic         hold_valid;
  logic [7:0]   hold_byte;
  logic         hold_last;
  logic         step;
  logic         out_full;
  result_beat_t res;

  assign step        = hold_valid && (!hold_last || !out_full || report.ready);
  assign bytes.ready = !hold_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (bytes.ready) begin
      hold_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      hold_byte <= bytes.table_byte;
      hold_last <= bytes.last_byte;
    end
  end

  aspscan_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .table_byte (hold_byte),
    .last_byte  (hold_last),
    .res        (res)
  );

  aspscan_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .res    (res),
    .full   (out_full),
    .report (report)
  );

  `ASP_ASSERT(a_no_overwrite, clk, rst, res.valid |-> (!out_full || report.ready),
    "report overwritten before it was taken")
  `ASP_ASSERT(a_ready_implies_step, clk, rst, (hold_valid && bytes.ready) |-> step,
    "input register refilled while its byte was still waiting")
  `ASP_ASSERT(a_report_follows_last, clk, rst,
    $rose(report.valid) |-> $past(step && hold_last),
    "report raised without a final byte")

endmodule
